// File: rtl/jkvl_pkg.sv
// Package for the JSON key/value locator.
// Holds the scan phase and value kind codes, character codes, the cell link
// and result types, and byte class helpers. No dependencies.
package jkvl_pkg;

  localparam int MAX_KEY_BYTES_DEF = 16;
  localparam int POSITION_BITS_DEF = 16;
  localparam int OFFSET_BITS       = 16;
  localparam int CFG_INDEX_BITS    = 2;
  localparam int CFG_DATA_BITS     = 64;
  localparam int KEY_LEN_BITS      = 5;
  localparam int DEPTH_BITS        = 16;

  // Configuration register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_KEY_LENGTH     = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_KEY_BYTES_LOW  = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_KEY_BYTES_HIGH = 2'd2;

  // Character codes
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;

  typedef enum logic [2:0] {
    PH_SEARCH,
    PH_KEY,
    PH_COLON,
    PH_OBJECT,
    PH_STRING,
    PH_NUMBER
  } phase_t;

  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_OBJECT = 2'd1,
    KIND_STRING = 2'd2,
    KIND_NUMBER = 2'd3
  } kind_t;

  // Byte handed from one window cell to the next
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } link_t;

  // Window control shared by all cells
  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctl_t;

  // One result transaction
  typedef struct packed {
    logic                   found;
    kind_t                  kind;
    logic [OFFSET_BITS-1:0] start;
    logic [OFFSET_BITS-1:0] length;
  } result_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

endpackage

// File: rtl/jkvl_cell.sv
// One slot of the key match window for the JSON key/value locator.
// Holds one byte and its valid bit, compares the incoming byte with its key byte.
// Depends on jkvl_pkg.
module jkvl_cell
  import jkvl_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cell_ctl_t  ctl,
  input  link_t      link_in,
  input  logic       active,
  input  logic [7:0] key_byte,
  output link_t      link_out,
  output logic       hit
);

  logic       valid_r, valid_nxt;
  logic [7:0] data_r,  data_nxt;

  // Clear on end of text, take neighbor's byte on shift, else hold
  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    if (ctl.clear) begin
      valid_nxt = 1'b0;
      data_nxt  = 8'h00;
    end else if (ctl.shift) begin
      valid_nxt = link_in.valid;
      data_nxt  = link_in.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  // Compare the byte that shifts in; slots past the key length always agree
  assign hit = !active || (link_in.valid && (link_in.data == key_byte));

  assign link_out.valid = valid_r;
  assign link_out.data  = data_r;

endmodule

// File: rtl/jkvl_skid.sv
// Two-entry result buffer for the JSON key/value locator.
// Output register plus skid register so the scanner keeps running while a
// result waits. Depends on jkvl_pkg.
module jkvl_skid
  import jkvl_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  result_t push_data,
  output logic    space,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  logic    out_valid_r,  out_valid_nxt;
  logic    skid_valid_r, skid_valid_nxt;
  result_t out_data_r,   out_data_nxt;
  result_t skid_data_r,  skid_data_nxt;

  // Refill the output register from the skid first, then from a new push
  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_data_nxt   = out_data_r;
    skid_data_nxt  = skid_data_r;
    if (!out_valid_r || out_ready) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else if (push) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = push_data;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end else if (push) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign space     = !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: rtl/json_key_value_locator.sv
// JSON key/value locator: one text byte per transaction, one result per text.
// Throughput: one byte per cycle while the result buffer has space; the key window is a chain of byte cells that
// shifts while searching and compares every slot in the cycle the byte is accepted.
// The result is registered in the result buffer's output register, or in its skid register while the output waits.
// Reset (synchronous, rst_n low): window, position, phase and result buffer
// cleared; key_length reads 1, key bytes 0.
module json_key_value_locator
  import jkvl_pkg::*;
#(
  parameter int MAX_KEY_BYTES = MAX_KEY_BYTES_DEF,
  parameter int POSITION_BITS = POSITION_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // Text bytes
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [7:0]                in_tdata,   // [7:0] char_byte
  input  logic                      in_tlast,   // is_last
  // Results
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [31:0]               out_tdata,  // [15:0] value_start, [31:16] value_length
  output logic [2:0]                out_tuser,  // [0] found, [2:1] value_kind
  // Configuration writes
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  localparam int LW  = $clog2(MAX_KEY_BYTES + 1);
  localparam int KIW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
  localparam int PB  = POSITION_BITS;

  // Configuration registers
  logic [KEY_LEN_BITS-1:0]  key_length_r;
  logic [CFG_DATA_BITS-1:0] key_low_r;
  logic [CFG_DATA_BITS-1:0] key_high_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_length_r <= KEY_LEN_BITS'(1);
      key_low_r    <= '0;
      key_high_r   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_KEY_LENGTH:     key_length_r <= cfg_data[KEY_LEN_BITS-1:0];
        REG_KEY_BYTES_LOW:  key_low_r    <= cfg_data;
        REG_KEY_BYTES_HIGH: key_high_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Scanner state
  phase_t                phase_r,  phase_nxt;
  logic [PB-1:0]         pos_r;
  logic [DEPTH_BITS-1:0] depth_r,  depth_nxt;
  logic [PB-1:0]         span_r,   span_nxt;
  logic                  answer_r;

  logic       in_fire;
  logic [7:0] c;
  logic       last;
  logic       space_ok;

  assign c         = in_tdata;
  assign last      = in_tlast;
  assign in_tready = space_ok;
  assign in_fire   = in_tvalid && in_tready;

  // Key bytes laid out by index, zero beyond the sixteenth
  logic [7:0]       key_arr [MAX_KEY_BYTES];
  logic [LW-1:0]    eff_len;
  logic [7:0]       key_sel [MAX_KEY_BYTES];
  logic [MAX_KEY_BYTES-1:0] active;

  always_comb begin
    for (int j = 0; j < MAX_KEY_BYTES; j++) begin
      if (j < 8) begin
        key_arr[j] = key_low_r[(j % 8) * 8 +: 8];
      end else if (j < 16) begin
        key_arr[j] = key_high_r[(j % 8) * 8 +: 8];
      end else begin
        key_arr[j] = 8'h00;
      end
    end
  end

  // Clamp key length to one through the window size
  always_comb begin
    int len;
    len = int'(key_length_r);
    if (len == 0) begin
      len = 1;
    end else if (len > MAX_KEY_BYTES) begin
      len = MAX_KEY_BYTES;
    end
    eff_len = LW'(len);
  end

  // Slot i, holding the i-th newest byte, checks key byte len-1-i
  always_comb begin
    for (int i = 0; i < MAX_KEY_BYTES; i++) begin
      if (i < int'(eff_len)) begin
        active[i]  = 1'b1;
        key_sel[i] = key_arr[KIW'(int'(eff_len) - 1 - i)];
      end else begin
        active[i]  = 1'b0;
        key_sel[i] = 8'h00;
      end
    end
  end

  // Window cell chain, slot 0 takes the new byte
  cell_ctl_t                ctl;
  link_t                    links [MAX_KEY_BYTES+1];
  logic [MAX_KEY_BYTES-1:0] hits;
  logic                     key_match;

  assign ctl.clear      = in_fire && last;
  assign ctl.shift      = in_fire && !answer_r && (phase_r == PH_SEARCH);
  assign links[0].valid = 1'b1;
  assign links[0].data  = c;

  for (genvar g = 0; g < MAX_KEY_BYTES; g++) begin : g_cell
    jkvl_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .link_in  (links[g]),
      .active   (active[g]),
      .key_byte (key_sel[g]),
      .link_out (links[g+1]),
      .hit      (hits[g])
    );
  end

  assign key_match = &hits;

  // Next phase, depth and span start
  always_comb begin
    phase_nxt = phase_r;
    depth_nxt = depth_r;
    span_nxt  = span_r;
    if (!answer_r) begin
      unique case (phase_r)
        PH_SEARCH: begin
          if (key_match) phase_nxt = PH_KEY;
        end
        PH_KEY: begin
          if ((c == CH_COLON) && !last) phase_nxt = PH_COLON;
        end
        PH_COLON: begin
          if (c == CH_LBRACE) begin
            phase_nxt = PH_OBJECT;
            depth_nxt = DEPTH_BITS'(1);
            span_nxt  = pos_r + PB'(1);
          end else if (c == CH_QUOTE) begin
            phase_nxt = PH_STRING;
            span_nxt  = pos_r + PB'(1);
          end else if (is_digit(c)) begin
            span_nxt = pos_r;
            if (!last) phase_nxt = PH_NUMBER;
          end
        end
        PH_OBJECT: begin
          if (c == CH_LBRACE) begin
            if (depth_r != {DEPTH_BITS{1'b1}}) depth_nxt = depth_r + DEPTH_BITS'(1);
          end else if (c == CH_RBRACE) begin
            if (depth_r != '0) depth_nxt = depth_r - DEPTH_BITS'(1);
          end
        end
        PH_STRING: ;
        PH_NUMBER: ;
        default: ;
      endcase
    end
  end

  // Result decision
  logic          emit;
  result_t       res;
  logic [PB-1:0] span_len;
  logic [PB-1:0] pos_inc;

  assign span_len = pos_r - span_r;
  assign pos_inc  = pos_r + PB'(1);

  always_comb begin
    emit       = 1'b0;
    res.found  = 1'b0;
    res.kind   = KIND_NONE;
    res.start  = '0;
    res.length = '0;
    if (!answer_r) begin
      unique case (phase_r)
        PH_SEARCH: ;
        PH_KEY: begin
          if (c == CH_COLON) begin
            if (last) emit = 1'b1;
          end else if (!is_space(c)) begin
            emit = 1'b1;
          end
        end
        PH_COLON: begin
          if (is_space(c) || (c == CH_LBRACE) || (c == CH_QUOTE)) begin
            emit = 1'b0;
          end else if (is_digit(c)) begin
            if (last) begin
              emit       = 1'b1;
              res.found  = 1'b1;
              res.kind   = KIND_NUMBER;
              res.start  = OFFSET_BITS'(pos_r);
              res.length = OFFSET_BITS'(1);
            end
          end else begin
            emit = 1'b1;
          end
        end
        PH_OBJECT: begin
          if ((c == CH_RBRACE) && (depth_nxt == '0)) begin
            emit       = 1'b1;
            res.found  = 1'b1;
            res.kind   = KIND_OBJECT;
            res.start  = OFFSET_BITS'(span_r);
            res.length = OFFSET_BITS'(span_len);
          end
        end
        PH_STRING: begin
          if (c == CH_QUOTE) begin
            emit       = 1'b1;
            res.found  = 1'b1;
            res.kind   = KIND_STRING;
            res.start  = OFFSET_BITS'(span_r);
            res.length = OFFSET_BITS'(span_len);
          end
        end
        PH_NUMBER: begin
          if (!is_digit(c)) begin
            emit       = 1'b1;
            res.found  = 1'b1;
            res.kind   = KIND_NUMBER;
            res.start  = OFFSET_BITS'(span_r);
            res.length = OFFSET_BITS'(span_len);
          end else if (last) begin
            emit       = 1'b1;
            res.found  = 1'b1;
            res.kind   = KIND_NUMBER;
            res.start  = OFFSET_BITS'(span_r);
            res.length = OFFSET_BITS'(pos_inc - span_r);
          end
        end
        default: emit = 1'b1;
      endcase
      // Undecided at end of text: report failure
      if (!emit && last) emit = 1'b1;
    end
  end

  // Advance scanner state per accepted byte; end of text starts a new one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_SEARCH;
      pos_r    <= '0;
      depth_r  <= '0;
      span_r   <= '0;
      answer_r <= 1'b0;
    end else if (in_fire) begin
      if (last) begin
        phase_r  <= PH_SEARCH;
        pos_r    <= '0;
        depth_r  <= '0;
        span_r   <= '0;
        answer_r <= 1'b0;
      end else begin
        phase_r  <= phase_nxt;
        pos_r    <= pos_inc;
        depth_r  <= depth_nxt;
        span_r   <= span_nxt;
        answer_r <= answer_r || emit;
      end
    end
  end

  // Result buffer
  result_t out_res;

  jkvl_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_fire && emit),
    .push_data (res),
    .space     (space_ok),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_res)
  );

  assign out_tdata = {out_res.length, out_res.start};
  assign out_tuser = {out_res.kind, out_res.found};

endmodule
